>>> rtl/core/spti_pkg.sv
// Shared constants, payload types and pipeline types for the segment pair intersect block.
`timescale 1ns / 1ps
`default_nettype none
package spti_pkg;

  // Field formats
  localparam int COORD_BITS      = 24;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int PARAM_BITS      = 32;
  localparam int TOL_BITS        = 23;
  localparam int THR_BITS        = 32;
  localparam int RATIO_BITS      = 24;
  localparam int RATIO_FRAC_BITS = 24;
  localparam int CFG_BITS        = 32;
  localparam int CFG_IDX_BITS    = 2;

  // Internal widths
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int DOT_BITS  = 2 * DIFF_BITS + 2;
  localparam int NUM_BITS  = DOT_BITS + 1;
  localparam int PROD_BITS = 2 * DOT_BITS;
  localparam int QPT_BITS  = PARAM_FRAC_BITS + 1;
  localparam int MUL_BITS  = QPT_BITS + 1 + DIFF_BITS;
  localparam int SUM_BITS  = MUL_BITS - PARAM_FRAC_BITS + 1;
  localparam int SQ_BITS   = 2 * DIFF_BITS;
  localparam int GAP_BITS  = SQ_BITS + 2;
  localparam int TOL2_BITS = 2 * TOL_BITS;
  localparam int RAT_BITS  = NUM_BITS + RATIO_BITS;

  // Divider geometry: one quotient bit per stage plus an overflow bit
  localparam int QUO_BITS   = PARAM_BITS + 1;
  localparam int REM_BITS   = PROD_BITS + QUO_BITS + 2;
  localparam int DIV_STAGES = QUO_BITS + 1;
  localparam int DIV_LAT    = DIV_STAGES + 2;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PARALLEL  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RATIO     = 2'd2;

  // Register reset values
  localparam logic [TOL_BITS-1:0]   TOL_RESET   = TOL_BITS'(256);
  localparam logic [THR_BITS-1:0]   THR_RESET   = THR_BITS'(1);
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(168);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef coord_t [2:0]          cvec_t;
  typedef logic [DIFF_BITS-1:0]  diff_t;
  typedef diff_t [2:0]           dvec_t;

  // Which solution path an item takes
  typedef enum logic [2:0] {
    CASE_PAR,
    CASE_IN,
    CASE_TLO,
    CASE_THI,
    CASE_ULO,
    CASE_UHI
  } case_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] query_start_x;
    logic signed [COORD_BITS-1:0] query_start_y;
    logic signed [COORD_BITS-1:0] query_start_z;
    logic signed [COORD_BITS-1:0] query_end_x;
    logic signed [COORD_BITS-1:0] query_end_y;
    logic signed [COORD_BITS-1:0] query_end_z;
    logic signed [COORD_BITS-1:0] cell_start_x;
    logic signed [COORD_BITS-1:0] cell_start_y;
    logic signed [COORD_BITS-1:0] cell_start_z;
    logic signed [COORD_BITS-1:0] cell_end_x;
    logic signed [COORD_BITS-1:0] cell_end_y;
    logic signed [COORD_BITS-1:0] cell_end_z;
  } req_t;

  typedef struct packed {
    logic                         hit;
    logic signed [PARAM_BITS-1:0] param_query;
    logic signed [PARAM_BITS-1:0] param_cell;
    logic signed [COORD_BITS-1:0] meet_x;
    logic signed [COORD_BITS-1:0] meet_y;
    logic signed [COORD_BITS-1:0] meet_z;
  } res_t;

  // Data that rides alongside the dividers
  typedef struct packed {
    case_t code;
    logic  degen;
    logic  numneg;
    logic  numgt;
    cvec_t base1;
    dvec_t dir1;
    cvec_t base2;
    dvec_t dir2;
  } side_t;

endpackage
`default_nettype wire

>>> rtl/core/spti_div.sv
// Pipelined rounding divider: saturated round(num * 2^frac / den), one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module spti_div (
  input  logic                                  clk,
  input  logic signed [spti_pkg::PROD_BITS-1:0] num,
  input  logic        [spti_pkg::PROD_BITS-1:0] den,
  output logic signed [spti_pkg::PARAM_BITS-1:0] quo
);
  import spti_pkg::*;

  localparam logic [QUO_BITS:0] MAG_POS = {3'b000, {(PARAM_BITS-1){1'b1}}};
  localparam logic [QUO_BITS:0] MAG_NEG = {3'b001, {(PARAM_BITS-1){1'b0}}};
  localparam logic [PARAM_BITS-1:0] PMAX = {1'b0, {(PARAM_BITS-1){1'b1}}};
  localparam logic [PARAM_BITS-1:0] PMIN = {1'b1, {(PARAM_BITS-1){1'b0}}};

  logic [REM_BITS-1:0]  rem [DIV_STAGES+1];
  logic [PROD_BITS:0]   dd  [DIV_STAGES+1];
  logic                 neg [DIV_STAGES+1];
  logic [QUO_BITS:0]    qb  [DIV_STAGES+1];
  logic [PROD_BITS-1:0] anum;
  logic [QUO_BITS:0]    mag;

  // Prep: magnitude, rounding offset folded into the dividend
  assign anum = num[PROD_BITS-1] ? PROD_BITS'(-num) : num;

  always_ff @(posedge clk) begin
    rem[0] <= (REM_BITS'(anum) << (PARAM_FRAC_BITS + 1)) + REM_BITS'(den);
    dd[0]  <= {den, 1'b0};
    neg[0] <= num[PROD_BITS-1];
    qb[0]  <= '0;
  end

  // Restoring steps, top step flags overflow
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
    localparam int K = QUO_BITS - j;
    logic [REM_BITS-1:0] sub;
    logic                ge;
    assign sub = REM_BITS'(dd[j]) << K;
    assign ge  = rem[j] >= sub;
    always_ff @(posedge clk) begin
      rem[j+1] <= ge ? rem[j] - sub : rem[j];
      dd[j+1]  <= dd[j];
      neg[j+1] <= neg[j];
      qb[j+1]  <= {qb[j][QUO_BITS-1:0], ge};
    end
  end

  // Sign and saturation
  assign mag = qb[DIV_STAGES];
  always_ff @(posedge clk) begin
    if (neg[DIV_STAGES]) begin
      quo <= (mag > MAG_NEG) ? PMIN : PARAM_BITS'(~mag + 1'b1);
    end else begin
      quo <= (mag > MAG_POS) ? PMAX : mag[PARAM_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/segment_pair_tolerant_intersect_top.sv
// Top level: streaming closest-approach test between a query and a cell segment in 3D.
// Throughput: one request per cycle; busy is low except the cycle after reset is seen.
// The two rounding dividers (34 steps plus prep and output) set the depth;
// everything else is nine stages. Results are strobed for one cycle on done.
// Reset (rst, synchronous) clears all valid bits and loads register reset values.
`timescale 1ns / 1ps
`default_nettype none
module segment_pair_tolerant_intersect_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  spti_pkg::req_t                     req,
  output logic                               done,
  output spti_pkg::res_t                     result,
  input  logic                               cfg_we,
  input  logic [spti_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [spti_pkg::CFG_BITS-1:0]      cfg_data
);
  import spti_pkg::*;

  localparam int LATENCY = 9 + DIV_LAT;
  localparam logic [PARAM_BITS-1:0] PONE_P = PARAM_BITS'(1 << PARAM_FRAC_BITS);
  localparam logic [QPT_BITS-1:0]   PONE_Q = {1'b1, {PARAM_FRAC_BITS{1'b0}}};
  localparam int CMP_BITS = (GAP_BITS > TOL2_BITS) ? GAP_BITS : TOL2_BITS;
  localparam logic signed [SUM_BITS-1:0] SUM_CMAX = SUM_BITS'(2**(COORD_BITS-1) - 1);
  localparam logic signed [SUM_BITS-1:0] SUM_CMIN = SUM_BITS'(-(2**(COORD_BITS-1)));
  localparam logic [MUL_BITS-1:0] HALF = MUL_BITS'(1 << (PARAM_FRAC_BITS - 1));
  // Split of the wide system products into half-width partial products
  localparam int HB  = DOT_BITS / 2;
  localparam int HW  = HB + 1;
  localparam int PPW = 2 * HB + 2;
  // Split of the ratio product in the side line
  localparam int RLO = NUM_BITS / 2 + 1;

  // Point on a segment: base + round(m / 2^frac), clamped to the coordinate range
  function automatic logic [COORD_BITS-1:0] seg_coord(input logic signed [MUL_BITS-1:0] m,
                                                     input logic signed [COORD_BITS-1:0] base);
    logic signed [MUL_BITS-1:0] adj;
    logic signed [SUM_BITS-1:0] s;
    adj = m + HALF - MUL_BITS'(m[MUL_BITS-1]);
    s   = SUM_BITS'(adj >>> PARAM_FRAC_BITS) + SUM_BITS'(base);
    if (s > SUM_CMAX) begin
      return SUM_CMAX[COORD_BITS-1:0];
    end else if (s < SUM_CMIN) begin
      return SUM_CMIN[COORD_BITS-1:0];
    end
    return s[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [DOT_BITS-1:0] dot3(input dvec_t a, input dvec_t b);
    logic signed [DOT_BITS-1:0] s;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      s = s + $signed(a[i]) * $signed(b[i]);
    end
    return s;
  endfunction

  // Four half-width partial products {hi*hi, hi*lo, lo*hi, lo*lo}
  function automatic logic [4*PPW-1:0] part_mul(input logic signed [DOT_BITS-1:0] a,
                                               input logic signed [DOT_BITS-1:0] b);
    logic signed [HW-1:0]  ah, al, bh, bl;
    logic signed [PPW-1:0] hh, hl, lh, ll;
    ah = HW'(a >>> HB);
    al = {1'b0, a[HB-1:0]};
    bh = HW'(b >>> HB);
    bl = {1'b0, b[HB-1:0]};
    hh = ah * bh;
    hl = ah * bl;
    lh = al * bh;
    ll = al * bl;
    return {hh, hl, lh, ll};
  endfunction

  // Recombine partial products into the full signed product
  function automatic logic signed [PROD_BITS-1:0] sum_parts(input logic [4*PPW-1:0] p);
    logic signed [PPW-1:0] hh, hl, lh, ll;
    {hh, hl, lh, ll} = p;
    return (PROD_BITS'(hh) <<< (2 * HB)) + (PROD_BITS'(hl) <<< HB) +
           (PROD_BITS'(lh) <<< HB) + PROD_BITS'(ll);
  endfunction

  logic accept;

  // Configuration registers
  logic [TOL_BITS-1:0]   tol;
  logic [THR_BITS-1:0]   thr;
  logic [RATIO_BITS-1:0] ratio;
  logic [TOL2_BITS-1:0]  tol_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol   <= TOL_RESET;
      thr   <= THR_RESET;
      ratio <= RATIO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOLERANCE: tol   <= cfg_data[TOL_BITS-1:0];
        CFG_PARALLEL:  thr   <= cfg_data[THR_BITS-1:0];
        CFG_RATIO:     ratio <= cfg_data[RATIO_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tol_sq <= TOL2_BITS'(tol) * TOL2_BITS'(tol);
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  // Stage 1: latch endpoints, form direction and offset vectors
  cvec_t ia1, ia2, ib1, ib2;
  cvec_t a1_1, a2_1, b1_1, b2_1;
  dvec_t d_1, e_1, w_1;
  logic  v1;

  assign ia1 = {req.query_start_z, req.query_start_y, req.query_start_x};
  assign ia2 = {req.query_end_z, req.query_end_y, req.query_end_x};
  assign ib1 = {req.cell_start_z, req.cell_start_y, req.cell_start_x};
  assign ib2 = {req.cell_end_z, req.cell_end_y, req.cell_end_x};

  always_ff @(posedge clk) begin
    v1 <= rst ? 1'b0 : accept;
  end

  always_ff @(posedge clk) begin
    a1_1 <= ia1;
    a2_1 <= ia2;
    b1_1 <= ib1;
    b2_1 <= ib2;
    for (int i = 0; i < 3; i++) begin
      d_1[i] <= DIFF_BITS'($signed(ia2[i])) - DIFF_BITS'($signed(ia1[i]));
      e_1[i] <= DIFF_BITS'($signed(ib2[i])) - DIFF_BITS'($signed(ib1[i]));
      w_1[i] <= DIFF_BITS'($signed(ib1[i])) - DIFF_BITS'($signed(ia1[i]));
    end
  end

  // Stage 2: dot products
  cvec_t a1_2, a2_2, b1_2, b2_2;
  dvec_t d_2, e_2;
  logic signed [DOT_BITS-1:0] s00_2, s11_2, de_2, dw_2, ew_2;
  logic v2;

  always_ff @(posedge clk) begin
    v2 <= rst ? 1'b0 : v1;
  end

  always_ff @(posedge clk) begin
    a1_2  <= a1_1;
    a2_2  <= a2_1;
    b1_2  <= b1_1;
    b2_2  <= b2_1;
    d_2   <= d_1;
    e_2   <= e_1;
    s00_2 <= dot3(d_1, d_1);
    s11_2 <= dot3(e_1, e_1);
    de_2  <= dot3(d_1, e_1);
    dw_2  <= dot3(d_1, w_1);
    ew_2  <= dot3(e_1, w_1);
  end

  // Stage M: partial products of the 2x2 system
  cvec_t a1_m, a2_m, b1_m, b2_m;
  dvec_t d_m, e_m;
  logic signed [DOT_BITS-1:0] s00_m, s11_m, de_m, dw_m, ew_m;
  logic [4*PPW-1:0] pss_m, pdede_m, pdws_m, pdeew_m, pdedw_m, psew_m;
  logic v_m;

  always_ff @(posedge clk) begin
    v_m <= rst ? 1'b0 : v2;
  end

  always_ff @(posedge clk) begin
    a1_m    <= a1_2;
    a2_m    <= a2_2;
    b1_m    <= b1_2;
    b2_m    <= b2_2;
    d_m     <= d_2;
    e_m     <= e_2;
    s00_m   <= s00_2;
    s11_m   <= s11_2;
    de_m    <= de_2;
    dw_m    <= dw_2;
    ew_m    <= ew_2;
    pss_m   <= part_mul(s00_2, s11_2);
    pdede_m <= part_mul(de_2, de_2);
    pdws_m  <= part_mul(dw_2, s11_2);
    pdeew_m <= part_mul(de_2, ew_2);
    pdedw_m <= part_mul(de_2, dw_2);
    psew_m  <= part_mul(s00_2, ew_2);
  end

  // Stage 3: products of the 2x2 system, endpoint numerators
  cvec_t a1_3, a2_3, b1_3, b2_3;
  dvec_t d_3, e_3;
  logic signed [PROD_BITS-1:0] pss_3, pdede_3, pdws_3, pdeew_3, pdedw_3, psew_3;
  logic signed [NUM_BITS-1:0]  ntlo_3, nthi_3, nulo_3, nuhi_3;
  logic signed [DOT_BITS-1:0]  s00_3, s11_3;
  logic v3;

  always_ff @(posedge clk) begin
    v3 <= rst ? 1'b0 : v_m;
  end

  always_ff @(posedge clk) begin
    a1_3    <= a1_m;
    a2_3    <= a2_m;
    b1_3    <= b1_m;
    b2_3    <= b2_m;
    d_3     <= d_m;
    e_3     <= e_m;
    s00_3   <= s00_m;
    s11_3   <= s11_m;
    pss_3   <= sum_parts(pss_m);
    pdede_3 <= sum_parts(pdede_m);
    pdws_3  <= sum_parts(pdws_m);
    pdeew_3 <= sum_parts(pdeew_m);
    pdedw_3 <= sum_parts(pdedw_m);
    psew_3  <= sum_parts(psew_m);
    ntlo_3  <= -NUM_BITS'(ew_m);
    nthi_3  <= NUM_BITS'(de_m) - NUM_BITS'(ew_m);
    nulo_3  <= NUM_BITS'(dw_m);
    nuhi_3  <= NUM_BITS'(de_m) + NUM_BITS'(dw_m);
  end

  // Stage 4: determinant, classification, divider operand select
  logic signed [PROD_BITS-1:0] det, nt, nu;
  logic  in_range, par;
  case_t code_c;
  logic signed [NUM_BITS-1:0]  pnum_c;
  logic signed [DOT_BITS-1:0]  pden_c;

  assign det      = pss_3 - pdede_3;
  assign nt       = pdws_3 - pdeew_3;
  assign nu       = pdedw_3 - psew_3;
  assign par      = !(det > $signed(PROD_BITS'({1'b0, thr})));
  assign in_range = !nt[PROD_BITS-1] && (nt <= det) && !nu[PROD_BITS-1] && (nu <= det);

  always_comb begin
    if (par) begin
      code_c = CASE_PAR;
    end else if (in_range) begin
      code_c = CASE_IN;
    end else if (nt[PROD_BITS-1]) begin
      code_c = CASE_TLO;
    end else if (nt > det) begin
      code_c = CASE_THI;
    end else if (nu[PROD_BITS-1]) begin
      code_c = CASE_ULO;
    end else begin
      code_c = CASE_UHI;
    end
  end

  always_comb begin
    case (code_c)
      CASE_TLO: begin pnum_c = ntlo_3; pden_c = s11_3; end
      CASE_THI: begin pnum_c = nthi_3; pden_c = s11_3; end
      CASE_ULO: begin pnum_c = nulo_3; pden_c = s00_3; end
      default:  begin pnum_c = nuhi_3; pden_c = s00_3; end
    endcase
  end

  logic signed [PROD_BITS-1:0] na_4, nb_4;
  logic        [PROD_BITS-1:0] da_4, db_4;
  logic signed [NUM_BITS-1:0]  pnum_4;
  logic signed [DOT_BITS-1:0]  pden_4;
  side_t side_4;
  logic  v4;

  always_ff @(posedge clk) begin
    v4 <= rst ? 1'b0 : v3;
  end

  always_ff @(posedge clk) begin
    na_4   <= (code_c == CASE_IN) ? nt : PROD_BITS'(pnum_c);
    da_4   <= (code_c == CASE_IN) ? det : PROD_BITS'(pden_c);
    nb_4   <= nu;
    db_4   <= det;
    pnum_4 <= pnum_c;
    pden_4 <= pden_c;
    side_4.code   <= code_c;
    side_4.degen  <= 1'b0;
    side_4.numneg <= 1'b0;
    side_4.numgt  <= 1'b0;
    side_4.dir2   <= d_3;
    case (code_c)
      CASE_ULO, CASE_UHI: begin
        side_4.base1 <= a1_3;
        side_4.dir1  <= d_3;
        side_4.base2 <= (code_c == CASE_ULO) ? b1_3 : b2_3;
      end
      CASE_THI: begin
        side_4.base1 <= b1_3;
        side_4.dir1  <= e_3;
        side_4.base2 <= a2_3;
      end
      default: begin
        side_4.base1 <= b1_3;
        side_4.dir1  <= e_3;
        side_4.base2 <= a1_3;
      end
    endcase
  end

  // Dividers: lane A carries t or the point parameter, lane B carries u
  logic signed [PARAM_BITS-1:0] qa, qb;

  spti_div u_div_a (
    .clk (clk),
    .num (na_4),
    .den (da_4),
    .quo (qa)
  );

  spti_div u_div_b (
    .clk (clk),
    .num (nb_4),
    .den (db_4),
    .quo (qb)
  );

  // Side line matched to divider latency; first slot adds sign flags, second the
  // degenerate flag from a split ratio product
  logic [NUM_BITS-1:0] anum;
  logic [RAT_BITS-1:0] rat_lhs, rat_rhs, lhs_q;
  logic [RATIO_BITS+RLO-1:0]          rp_lo;
  logic [RATIO_BITS+NUM_BITS-RLO-1:0] rp_hi;
  logic den_zero;
  side_t side_f, side_d;
  side_t side_q [DIV_LAT];
  logic [DIV_LAT-1:0] side_v;

  assign anum    = pnum_4[NUM_BITS-1] ? NUM_BITS'(-pnum_4) : pnum_4;
  assign rat_lhs = RAT_BITS'(pden_4) << RATIO_FRAC_BITS;
  assign rat_rhs = (RAT_BITS'(rp_hi) << RLO) + RAT_BITS'(rp_lo);

  always_comb begin
    side_f        = side_4;
    side_f.numneg = pnum_4[NUM_BITS-1];
    side_f.numgt  = NUM_BITS'(pden_4) < pnum_4;
  end

  always_comb begin
    side_d       = side_q[0];
    side_d.degen = den_zero || (lhs_q < rat_rhs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_v <= '0;
    end else begin
      side_v <= {side_v[DIV_LAT-2:0], v4};
    end
  end

  always_ff @(posedge clk) begin
    side_q[0] <= side_f;
    side_q[1] <= side_d;
    lhs_q     <= rat_lhs;
    den_zero  <= (pden_4 == '0);
    rp_lo     <= ratio * anum[RLO-1:0];
    rp_hi     <= ratio * anum[NUM_BITS-1:RLO];
    for (int j = 2; j < DIV_LAT; j++) begin
      side_q[j] <= side_q[j-1];
    end
  end

  // Stage P: map quotients to parameters, scale directions
  side_t sd;
  logic signed [PARAM_BITS-1:0] pp2s, tq_c, uq_c;
  logic [QPT_BITS-1:0] qpt, q1_c, q2_c;

  assign sd   = side_q[DIV_LAT-1];
  assign pp2s = sd.degen ? '0 : qa;
  assign qpt  = (sd.degen || sd.numneg) ? '0 : (sd.numgt ? PONE_Q : qa[QPT_BITS-1:0]);

  always_comb begin
    case (sd.code)
      CASE_IN:  begin tq_c = qa;     uq_c = qb;     q1_c = qb[QPT_BITS-1:0];
                      q2_c = qa[QPT_BITS-1:0]; end
      CASE_TLO: begin tq_c = '0;     uq_c = pp2s;   q1_c = qpt; q2_c = '0; end
      CASE_THI: begin tq_c = PONE_P; uq_c = pp2s;   q1_c = qpt; q2_c = '0; end
      CASE_ULO: begin tq_c = pp2s;   uq_c = '0;     q1_c = qpt; q2_c = '0; end
      CASE_UHI: begin tq_c = pp2s;   uq_c = PONE_P; q1_c = qpt; q2_c = '0; end
      default:  begin tq_c = '0;     uq_c = '0;     q1_c = '0;  q2_c = '0; end
    endcase
  end

  logic signed [MUL_BITS-1:0] m1_p [3];
  logic signed [MUL_BITS-1:0] m2_p [3];
  cvec_t base1_p, base2_p;
  logic signed [PARAM_BITS-1:0] tq_p, uq_p;
  logic par_p, v_p;

  always_ff @(posedge clk) begin
    v_p <= rst ? 1'b0 : side_v[DIV_LAT-1];
  end

  always_ff @(posedge clk) begin
    base1_p <= sd.base1;
    base2_p <= sd.base2;
    tq_p    <= tq_c;
    uq_p    <= uq_c;
    par_p   <= (sd.code == CASE_PAR);
    for (int i = 0; i < 3; i++) begin
      m1_p[i] <= $signed({1'b0, q1_c}) * $signed(sd.dir1[i]);
      m2_p[i] <= $signed({1'b0, q2_c}) * $signed(sd.dir2[i]);
    end
  end

  // Stage R: round and offset the two closest points
  cvec_t pt1_r, pt2_r;
  logic signed [PARAM_BITS-1:0] tq_r, uq_r;
  logic par_r, v_r;

  always_ff @(posedge clk) begin
    v_r <= rst ? 1'b0 : v_p;
  end

  always_ff @(posedge clk) begin
    tq_r  <= tq_p;
    uq_r  <= uq_p;
    par_r <= par_p;
    for (int i = 0; i < 3; i++) begin
      pt1_r[i] <= seg_coord(m1_p[i], $signed(base1_p[i]));
      pt2_r[i] <= seg_coord(m2_p[i], $signed(base2_p[i]));
    end
  end

  // Stage G: squared gap per axis
  logic [SQ_BITS-1:0] sq_g [3];
  cvec_t pt1_g;
  logic signed [PARAM_BITS-1:0] tq_g, uq_g;
  logic par_g, v_g;
  diff_t gd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gd[i] = DIFF_BITS'($signed(pt1_r[i])) - DIFF_BITS'($signed(pt2_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    v_g <= rst ? 1'b0 : v_r;
  end

  always_ff @(posedge clk) begin
    pt1_g <= pt1_r;
    tq_g  <= tq_r;
    uq_g  <= uq_r;
    par_g <= par_r;
    for (int i = 0; i < 3; i++) begin
      sq_g[i] <= $signed(gd[i]) * $signed(gd[i]);
    end
  end

  // Stage H: tolerance compare and result register
  logic [GAP_BITS-1:0] gap;
  res_t res_q;

  assign gap = GAP_BITS'(sq_g[0]) + GAP_BITS'(sq_g[1]) + GAP_BITS'(sq_g[2]);

  always_ff @(posedge clk) begin
    done <= rst ? 1'b0 : v_g;
  end

  always_ff @(posedge clk) begin
    res_q.hit         <= !par_g && (CMP_BITS'(gap) <= CMP_BITS'(tol_sq));
    res_q.param_query <= tq_g;
    res_q.param_cell  <= uq_g;
    res_q.meet_x      <= par_g ? '0 : pt1_g[0];
    res_q.meet_y      <= par_g ? '0 : pt1_g[1];
    res_q.meet_z      <= par_g ? '0 : pt1_g[2];
  end

  assign result = res_q;

`ifndef ASSERT_OFF
  // Every result traces back to one accepted request a fixed latency earlier
  a_done_from_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without a matching request");

  // Side line stays aligned with the dividers
  a_side_align: assert property (@(posedge clk) disable iff (rst)
    side_v[DIV_LAT-1] |-> $past(v4, DIV_LAT))
    else $error("side data misaligned with divider output");

  // Interior solutions give parameters within [0, 1]
  a_inside_range: assert property (@(posedge clk) disable iff (rst)
    (side_v[DIV_LAT-1] && sd.code == CASE_IN) |->
      (!qa[PARAM_BITS-1] && qa <= $signed(PONE_P) &&
       !qb[PARAM_BITS-1] && qb <= $signed(PONE_P)))
    else $error("interior parameter outside unit range");

  // Parallel requests never report a hit
  a_par_no_hit: assert property (@(posedge clk) disable iff (rst)
    (v_g && par_g) |=> !result.hit)
    else $error("hit reported on parallel segments");
`endif

endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the segment pair closest-approach intersect block.
`timescale 1ns / 1ps
module tb_top;
  import spti_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef wide_t vec3_t [3];

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int CMAX = 8388607;
  localparam int CMIN = -8388608;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT = 5000;
  localparam int RAND_PER_PHASE = 190;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  res_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_TOLERANCE;
  logic [CFG_BITS-1:0] cfg_data = '0;

  segment_pair_tolerant_intersect_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock: 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copies of the configuration registers
  logic [TOL_BITS-1:0]   tol_reg   = TOL_RESET;
  logic [THR_BITS-1:0]   thr_reg   = THR_RESET;
  logic [RATIO_BITS-1:0] ratio_reg = RATIO_RESET;

  req_t pending_q [$];
  res_t expected_q [$];
  int   idle_pct = 0;
  int   errors = 0;
  int   accepted = 0;
  int   hits_seen = 0;
  int   stall_cnt = 0;

  // ---------------- closest-approach predictor ----------------
  function automatic wide_t sext(logic [COORD_BITS-1:0] v);
    return {{(256-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic wide_t dot(vec3_t a, vec3_t b);
    return a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
  endfunction

  // round(n/d) half away from zero, d > 0
  function automatic wide_t div_round(wide_t n, wide_t d);
    wide_t an, q;
    an = (n < 0) ? -n : n;
    q = (2*an + d) / (2*d);
    return (n < 0) ? -q : q;
  endfunction

  function automatic wide_t sat(wide_t a, wide_t lo, wide_t hi);
    if (a < lo) return lo;
    if (a > hi) return hi;
    return a;
  endfunction

  function automatic wide_t param_q(wide_t n, wide_t d);
    return sat(div_round(n * wide_t'(65536), d), wide_t'(-64'sd2147483648),
               wide_t'(64'sd2147483647));
  endfunction

  function automatic vec3_t point_at(vec3_t p, vec3_t dir, wide_t q);
    vec3_t o;
    for (int i = 0; i < 3; i++)
      o[i] = sat(div_round(q * dir[i], wide_t'(65536)) + p[i], wide_t'(CMIN), wide_t'(CMAX));
    return o;
  endfunction

  function automatic wide_t gap2(vec3_t a, vec3_t b);
    vec3_t g;
    for (int i = 0; i < 3; i++) g[i] = a[i] - b[i];
    return dot(g, g);
  endfunction

  // closest point on p1..p2 to x; returns the squared gap
  function automatic wide_t near_on_seg(vec3_t x, vec3_t p1, vec3_t p2,
                                        output wide_t prm, output vec3_t pt);
    vec3_t r, xp;
    wide_t num, den, anum;
    for (int i = 0; i < 3; i++) begin
      r[i] = p2[i] - p1[i];
      xp[i] = x[i] - p1[i];
    end
    num = dot(r, xp);
    den = dot(r, r);
    anum = (num < 0) ? -num : num;
    if (den == 0 || den * (wide_t'(1) <<< 24) < wide_t'(ratio_reg) * anum) begin
      prm = 0;
      pt = p1;
    end else begin
      prm = param_q(num, den);
      if (num < 0) pt = p1;
      else if (num > den) pt = p2;
      else pt = point_at(p1, r, prm);
    end
    return gap2(pt, x);
  endfunction

  function automatic res_t predict_meet(req_t q);
    vec3_t a1, a2, b1, b2, d, e, w, meet, qp;
    wide_t s00, s11, de, dw, ew, det, nt, nu, gap, tq, uq;
    res_t r;
    a1 = '{sext(q.query_start_x), sext(q.query_start_y), sext(q.query_start_z)};
    a2 = '{sext(q.query_end_x), sext(q.query_end_y), sext(q.query_end_z)};
    b1 = '{sext(q.cell_start_x), sext(q.cell_start_y), sext(q.cell_start_z)};
    b2 = '{sext(q.cell_end_x), sext(q.cell_end_y), sext(q.cell_end_z)};
    for (int i = 0; i < 3; i++) begin
      d[i] = a2[i] - a1[i];
      e[i] = b2[i] - b1[i];
      w[i] = b1[i] - a1[i];
      meet[i] = 0;
    end
    s00 = dot(d, d); s11 = dot(e, e); de = dot(d, e);
    dw = dot(d, w);  ew = dot(e, w);
    det = s00*s11 - de*de;
    tq = 0; uq = 0;
    r = '0;
    if (det > wide_t'(thr_reg)) begin
      nt = dw*s11 - de*ew;
      nu = de*dw - s00*ew;
      if (nt >= 0 && nt <= det && nu >= 0 && nu <= det) begin
        tq = param_q(nt, det);
        uq = param_q(nu, det);
        meet = point_at(b1, e, uq);
        qp = point_at(a1, d, tq);
        gap = gap2(meet, qp);
      end else if (nt < 0) begin
        gap = near_on_seg(a1, b1, b2, uq, meet);
      end else if (nt > det) begin
        tq = 65536;
        gap = near_on_seg(a2, b1, b2, uq, meet);
      end else if (nu < 0) begin
        gap = near_on_seg(b1, a1, a2, tq, meet);
      end else begin
        uq = 65536;
        gap = near_on_seg(b2, a1, a2, tq, meet);
      end
      r.hit = (gap <= wide_t'(tol_reg) * wide_t'(tol_reg));
    end
    r.param_query = tq[31:0];
    r.param_cell  = uq[31:0];
    r.meet_x = meet[0][COORD_BITS-1:0];
    r.meet_y = meet[1][COORD_BITS-1:0];
    r.meet_z = meet[2][COORD_BITS-1:0];
    return r;
  endfunction

  // ---------------- request driver ----------------
  always @(negedge clk) begin
    if (!rst && pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
      start <= 1'b1;
      req <= pending_q[0];
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------- acceptance and result monitor ----------------
  function automatic void report(string name, logic [31:0] exp_v, logic [31:0] act_v);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t ns: result with nothing outstanding, actual %h", $time, result);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (result.hit !== exp_r.hit) begin report("hit", exp_r.hit, result.hit); errors++; end
        if (result.param_query !== exp_r.param_query) begin
          report("param_query", exp_r.param_query, result.param_query); errors++;
        end
        if (result.param_cell !== exp_r.param_cell) begin
          report("param_cell", exp_r.param_cell, result.param_cell); errors++;
        end
        if (result.meet_x !== exp_r.meet_x) begin
          report("meet_x", exp_r.meet_x, result.meet_x); errors++;
        end
        if (result.meet_y !== exp_r.meet_y) begin
          report("meet_y", exp_r.meet_y, result.meet_y); errors++;
        end
        if (result.meet_z !== exp_r.meet_z) begin
          report("meet_z", exp_r.meet_z, result.meet_z); errors++;
        end
        if (exp_r.hit) hits_seen++;
      end
    end
    if (!rst && start && !busy && pending_q.size() > 0) begin
      expected_q.push_back(predict_meet(req));
      void'(pending_q.pop_front());
      accepted++;
    end
  end

  // Watchdog: too long with work outstanding and no handshake
  always @(posedge clk) begin
    if (pending_q.size() > 0 || expected_q.size() > 0) begin
      if ((start && !busy) || done) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog expired at %0t ns", $time);
        $display("segment_pair_tolerant_intersect_top verification failed");
        $finish;
      end
    end else begin
      stall_cnt = 0;
    end
  end

  // ---------------- stimulus ----------------
  function automatic req_t mk(int ax, int ay, int az, int bx, int by, int bz,
                              int cx, int cy, int cz, int ex, int ey, int ez);
    req_t q;
    q.query_start_x = ax[23:0]; q.query_start_y = ay[23:0]; q.query_start_z = az[23:0];
    q.query_end_x   = bx[23:0]; q.query_end_y   = by[23:0]; q.query_end_z   = bz[23:0];
    q.cell_start_x  = cx[23:0]; q.cell_start_y  = cy[23:0]; q.cell_start_z  = cz[23:0];
    q.cell_end_x    = ex[23:0]; q.cell_end_y    = ey[23:0]; q.cell_end_z    = ez[23:0];
    return q;
  endfunction

  function automatic int rs(int span);
    return $urandom_range(0, 2*span) - span;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 3))
      0: return CMAX;
      1: return CMIN;
      2: return 0;
      default: return rs(CMAX);
    endcase
  endfunction

  function automatic req_t random_pair();
    req_t q;
    int p[3], da[3], db[3], sp, j;
    case ($urandom_range(0, 9))
      0, 1: q = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom});
      2, 3: begin
        sp = $urandom_range(0, 1) ? 2000 : 200000;
        q = mk(rs(sp), rs(sp), rs(sp), rs(sp), rs(sp), rs(sp),
               rs(sp), rs(sp), rs(sp), rs(sp), rs(sp), rs(sp));
      end
      4, 5, 6: begin
        // segments passing near a common point, ends spread to hit every clamp
        sp = $urandom_range(0, 1) ? 3000 : 1 << 20;
        j = $urandom_range(0, 600);
        for (int i = 0; i < 3; i++) begin
          p[i] = rs(1 << 22); da[i] = rs(sp); db[i] = rs(sp);
        end
        q = mk(p[0] - da[0], p[1] - da[1], p[2] - da[2],
               p[0] + da[0] * $urandom_range(0, 3) / 2, p[1] + da[1], p[2] + da[2],
               p[0] - db[0] + rs(j), p[1] - db[1] + rs(j), p[2] - db[2],
               p[0] + db[0] * $urandom_range(0, 3) / 2, p[1] + db[1], p[2] + db[2] + rs(j));
      end
      7: begin
        // parallel or nearly parallel
        for (int i = 0; i < 3; i++) begin p[i] = rs(1 << 21); da[i] = rs(50000); end
        j = $urandom_range(0, 2);
        q = mk(p[0], p[1], p[2], p[0] + da[0], p[1] + da[1], p[2] + da[2],
               p[0] + 300, p[1] - 77, p[2], p[0] + 300 + da[0] + j, p[1] - 77 + da[1],
               p[2] + da[2]);
      end
      8: begin
        // one very short segment against a long one
        for (int i = 0; i < 3; i++) begin p[i] = rs(1 << 21); da[i] = rs(1 << 21); end
        q = mk(p[0], p[1], p[2], p[0] + rs(3), p[1] + rs(3), p[2] + rs(3),
               p[0] - da[0], p[1] - da[1], p[2] - da[2], p[0] + da[0], p[1] + da[1],
               p[2] + da[2]);
        if ($urandom_range(0, 1)) q = {q[6*COORD_BITS-1:0], q[12*COORD_BITS-1:6*COORD_BITS]};
      end
      default: q = mk(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                      pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                      pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
    endcase
    return q;
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TOLERANCE: tol_reg = data[TOL_BITS-1:0];
      CFG_PARALLEL:  thr_reg = data[THR_BITS-1:0];
      CFG_RATIO:     ratio_reg = data[RATIO_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CFG_BITS-1:0] tol_set [5];
    logic [CFG_BITS-1:0] thr_set [5];
    logic [CFG_BITS-1:0] rat_set [5];
    int idle_set [5];
    tol_set = '{32'd256, 32'hFF80_0000, 32'h007F_FFFF, $urandom, 32'd3000};
    thr_set = '{32'd1, 32'd0, 32'hFFFF_FFFF, $urandom_range(0, 1 << 20), 32'd1 << 24};
    rat_set = '{32'd168, 32'hFF00_0000, 32'h00FF_FFFF, $urandom, 32'd16777};
    idle_set = '{0, 82, 0, 31, 82};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed requests under reset settings
    pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                           CMAX, CMAX));
    pending_q.push_back(mk(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                           CMIN, CMIN));
    pending_q.push_back(mk(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, 0, CMAX, CMIN, 0));
    pending_q.push_back(mk(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN,
                           CMIN, CMAX));
    pending_q.push_back(mk(-256, 0, 0, 256, 0, 0, 0, -256, 0, 0, 256, 0));
    pending_q.push_back(mk(-256, 0, 0, 256, 0, 0, 0, -256, 1000, 0, 256, 1000));
    pending_q.push_back(mk(256, 0, 0, 512, 0, 0, 0, -256, 0, 0, 256, 0));
    pending_q.push_back(mk(-512, 0, 0, -256, 0, 0, 0, -256, 0, 0, 256, 0));
    pending_q.push_back(mk(-256, 0, 0, 256, 0, 0, 0, 256, 0, 0, 512, 0));
    pending_q.push_back(mk(-256, 0, 0, 256, 0, 0, 0, -512, 0, 0, -256, 0));
    pending_q.push_back(mk(-256, 0, 0, 256, 0, 0, 0, -512, 40, 0, -256, 40));
    pending_q.push_back(mk(0, 0, 0, 1000, 0, 0, 0, 10, 0, 1000, 10, 0));
    pending_q.push_back(mk(0, 0, 0, 1, 0, 0, 0, 5, 0, 0, 5, 0));
    pending_q.push_back(mk(0, 0, 0, 1000, 0, 0, 0, 10, 0, 1000, 11, 0));
    pending_q.push_back(mk(-6000000, 0, 0, -6000000, 1, 0, 100, -3000000, 0,
                           100, 3000000, 1));
    pending_q.push_back(mk(100, -3000000, 0, 100, 3000000, 1, -6000000, 0, 0,
                           -6000000, 1, 0));
    pending_q.push_back(mk(32'h555555, 32'hAAAAAA, 32'h555555, 32'hAAAAAA, 32'h555555,
                           32'hAAAAAA, 32'hAAAAAA, 32'h555555, 32'hAAAAAA, 32'h555555,
                           32'hAAAAAA, 32'h555555));
    pending_q.push_back(mk(CMIN, 0, 0, CMAX, 0, 0, 0, CMIN, 0, 0, CMAX, 0));
    pending_q.push_back(mk(0, 0, 0, 1, 1, 1, 0, 1, 0, 1, 0, 1));
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_TOLERANCE, tol_set[ph]);
      write_reg(CFG_PARALLEL, thr_set[ph]);
      write_reg(CFG_RATIO, rat_set[ph]);
      write_reg(CFG_UNUSED, $urandom);
      idle_pct = idle_set[ph];
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        // idle-free stretches inside idling phases
        if (k % 64 == 40) idle_pct = 0;
        if (k % 64 == 52) idle_pct = idle_set[ph];
        pending_q.push_back(random_pair());
        if (pending_q.size() > 8) while (pending_q.size() > 4) @(posedge clk);
      end
      drain();
    end

    $display("covered %0d requests over 6 register settings, %0d reported hits",
             accepted, hits_seen);
    if (errors == 0) begin
      $display("segment_pair_tolerant_intersect_top verification clean");
    end else begin
      $display("segment_pair_tolerant_intersect_top verification failed");
    end
    $finish;
  end

endmodule
